### rtl/dfs_pkg.sv
`default_nettype none
package dfs_pkg;

  localparam int RANGE_COUNT_DEF    = 3;
  localparam int FIELD_NUM_BITS_DEF = 16;
  localparam int RANGE_SLOTS        = 3;
  localparam int CFG_INDEX_BITS     = 3;
  localparam int CFG_DATA_BITS      = 16;

  localparam logic [7:0]  NL_BYTE         = 8'd10;
  localparam logic [7:0]  DELIM_RESET     = 8'd9;
  localparam logic [15:0] RANGE_LO_RESET  = 16'd1;
  localparam logic [15:0] RANGE_HI_RESET  = 16'd0;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIM_PRIMARY   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIM_SECONDARY = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE0_LO       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE0_HI       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE1_LO       = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE1_HI       = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE2_LO       = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE2_HI       = 3'd7;

  typedef struct packed {
    logic [7:0]  delim_primary;
    logic [7:0]  delim_secondary;
    logic [RANGE_SLOTS-1:0][15:0] range_lo;
    logic [RANGE_SLOTS-1:0][15:0] range_hi;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } step_res_t;

endpackage
`default_nettype wire

### rtl/delimited_field_selector_unit.sv
`default_nettype none
// Field selector over a byte stream.
// Input channel (in_valid/in_ready) carries one text byte per transaction with
// end_of_stream marking the final byte. Output channel (out_valid/out_ready)
// carries the selected bytes, separators and newlines; last_of_run marks the
// final output byte caused by one input byte. An input byte causes zero, one
// or two output transactions.
// An accepted byte is held in the input register, then processed into the
// two-entry result buffer, from which its first result is offered.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver takes every result; a byte giving two results offers them
// one at a time through the single output port, and the next byte waits.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, which the block does not enforce.
// Reset clears the line state, empties both stages and restores register
// defaults. When the receiver stalls, the result buffer fills and the input
// register holds, deasserting in_ready.
module delimited_field_selector_unit
  import dfs_pkg::*;
#(
  parameter int RANGE_COUNT    = RANGE_COUNT_DEF,
  parameter int FIELD_NUM_BITS = FIELD_NUM_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                char_in,
  input  wire logic                      end_of_stream,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     char_out,
  output logic                           last_of_run,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  cfg_t       cfg;
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       eos_q;
  logic       can_take;
  logic       advance;
  step_res_t  res;

  assign advance  = in_valid_q && can_take;
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim_primary   <= DELIM_RESET;
      cfg.delim_secondary <= DELIM_RESET;
      for (int i = 0; i < RANGE_SLOTS; i++) begin
        cfg.range_lo[i] <= RANGE_LO_RESET;
        cfg.range_hi[i] <= RANGE_HI_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELIM_PRIMARY:   cfg.delim_primary   <= cfg_wdata[7:0];
        CFG_DELIM_SECONDARY: cfg.delim_secondary <= cfg_wdata[7:0];
        CFG_RANGE0_LO:       cfg.range_lo[0]     <= cfg_wdata;
        CFG_RANGE0_HI:       cfg.range_hi[0]     <= cfg_wdata;
        CFG_RANGE1_LO:       cfg.range_lo[1]     <= cfg_wdata;
        CFG_RANGE1_HI:       cfg.range_hi[1]     <= cfg_wdata;
        CFG_RANGE2_LO:       cfg.range_lo[2]     <= cfg_wdata;
        CFG_RANGE2_HI:       cfg.range_hi[2]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= char_in;
      eos_q  <= end_of_stream;
    end
  end

  dfs_core #(
    .RANGE_COUNT    (RANGE_COUNT),
    .FIELD_NUM_BITS (FIELD_NUM_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .char_q  (char_q),
    .eos_q   (eos_q),
    .cfg     (cfg),
    .res     (res)
  );

  dfs_obuf u_obuf (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .res         (res),
    .can_take    (can_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_out    (char_out),
    .last_of_run (last_of_run)
  );

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid_q && !can_take) |=> (in_valid_q && $stable(char_q) && $stable(eos_q)))
    else $error("input stage lost a byte while the result buffer was full");

  a_pair_shown: assert property (@(posedge clk) disable iff (rst)
    (advance && (res.count == 2'd2)) |=> (out_valid && !last_of_run))
    else $error("first of two results not offered");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (advance && (res.count == 2'd1)) |=> (out_valid && last_of_run))
    else $error("single result not marked last");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid_q && !can_take) |-> !in_ready)
    else $error("input accepted while the stage was blocked");

endmodule
`default_nettype wire

### rtl/dfs_core.sv
`default_nettype none
module dfs_core
  import dfs_pkg::*;
#(
  parameter int RANGE_COUNT    = RANGE_COUNT_DEF,
  parameter int FIELD_NUM_BITS = FIELD_NUM_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [7:0] char_q,
  input  wire logic       eos_q,
  input  wire cfg_t       cfg,
  output step_res_t       res
);

  localparam int CW = (FIELD_NUM_BITS > 16) ? FIELD_NUM_BITS : 16;

  logic                      in_field;
  logic                      in_field_next;
  logic [FIELD_NUM_BITS-1:0] field_number;
  logic [FIELD_NUM_BITS-1:0] field_number_next;
  logic                      field_selected;
  logic                      field_selected_next;
  logic                      line_has_output;
  logic                      line_has_output_next;

  logic                      is_nl;
  logic                      is_delim;
  logic                      start;
  logic [FIELD_NUM_BITS-1:0] fn_inc;
  logic [RANGE_COUNT-1:0]    hit;
  logic                      sel;
  logic                      sep;
  logic                      emit;

  always_comb begin
    is_nl    = (char_q == NL_BYTE);
    is_delim = (char_q == cfg.delim_primary) || (char_q == cfg.delim_secondary);
    start    = !is_nl && !is_delim && !in_field;
    fn_inc   = field_number;
    if (start && (field_number != {FIELD_NUM_BITS{1'b1}})) begin
      fn_inc = field_number + 1'b1;
    end
  end

  for (genvar i = 0; i < RANGE_COUNT; i++) begin : g_range
    assign hit[i] = (CW'(fn_inc) >= CW'(cfg.range_lo[i])) &&
                    (CW'(fn_inc) <= CW'(cfg.range_hi[i]));
  end

  always_comb begin
    sel  = start ? (|hit) : field_selected;
    sep  = start && sel && line_has_output;
    emit = !is_nl && !is_delim && sel;

    res.count = 2'd0;
    res.byte0 = NL_BYTE;
    res.byte1 = NL_BYTE;
    if (is_nl) begin
      res.count = 2'd1;
    end else if (sep) begin
      res.count = 2'd2;
      res.byte0 = cfg.delim_primary;
      res.byte1 = char_q;
    end else if (emit) begin
      res.byte0 = char_q;
      res.count = eos_q ? 2'd2 : 2'd1;
    end else if (eos_q) begin
      res.count = 2'd1;
    end

    in_field_next        = in_field;
    field_number_next    = field_number;
    field_selected_next  = field_selected;
    line_has_output_next = line_has_output;
    if (is_nl || eos_q) begin
      in_field_next        = 1'b0;
      field_number_next    = '0;
      field_selected_next  = 1'b0;
      line_has_output_next = 1'b0;
    end else if (is_delim) begin
      in_field_next = 1'b0;
    end else begin
      in_field_next        = 1'b1;
      field_number_next    = fn_inc;
      field_selected_next  = sel;
      line_has_output_next = line_has_output | emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_field        <= 1'b0;
      field_number    <= '0;
      field_selected  <= 1'b0;
      line_has_output <= 1'b0;
    end else if (advance) begin
      in_field        <= in_field_next;
      field_number    <= field_number_next;
      field_selected  <= field_selected_next;
      line_has_output <= line_has_output_next;
    end
  end

endmodule
`default_nettype wire

### rtl/dfs_obuf.sv
`default_nettype none
module dfs_obuf
  import dfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire step_res_t  res,
  output logic            can_take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      char_out,
  output logic            last_of_run
);

  logic [1:0] count;
  logic [7:0] byte0;
  logic       last0;
  logic [7:0] byte1;

  logic pop;

  assign pop         = out_valid && out_ready;
  assign can_take    = (count == 2'd0) || ((count == 2'd1) && out_ready);
  assign out_valid   = (count != 2'd0);
  assign char_out    = byte0;
  assign last_of_run = last0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= res.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte0 <= res.byte0;
      last0 <= (res.count == 2'd1);
      byte1 <= res.byte1;
    end else if (pop) begin
      byte0 <= byte1;
      last0 <= 1'b1;
    end
  end

endmodule
`default_nettype wire
